>>> rtl/core/bcmc_pkg.sv
// Shared types and constants for the button click mode controller.
`default_nettype none

package bcmc_pkg;

    typedef logic [1:0] mode_t;
    typedef logic [1:0] press_t;

    // Mode codes.
    localparam mode_t MODE_OFF    = 2'd0;
    localparam mode_t MODE_SLOW   = 2'd1;
    localparam mode_t MODE_FAST   = 2'd2;
    localparam mode_t MODE_STEADY = 2'd3;

    // Press state codes.
    localparam press_t PRESS_OFF  = 2'd0;
    localparam press_t PRESS_ON   = 2'd1;
    localparam press_t PRESS_LONG = 2'd2;

    // Configuration port.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LONG_PRESS = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DBL_CLICK  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SLOW_BLINK = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_FAST_BLINK = 3'd4;

    localparam logic [7:0]  DEBOUNCE_RESET   = 8'd50;
    localparam logic [15:0] LONG_PRESS_RESET = 16'd1000;
    localparam logic [15:0] DBL_CLICK_RESET  = 16'd300;
    localparam logic [15:0] SLOW_BLINK_RESET = 16'd1000;
    localparam logic [15:0] FAST_BLINK_RESET = 16'd200;

    // Color constants.
    localparam logic [8:0] HUE_RESET = 9'd356;
    localparam logic [8:0] HUE_WRAP  = 9'd360;
    localparam logic [8:0] HUE_STEP  = 9'd3;
    localparam logic [7:0] SV_RESET  = 8'd255;
    localparam logic [7:0] SV_LIMIT  = 8'd250;
    localparam logic [7:0] SV_STEP   = 8'd5;

    // Color step request from the control logic to the color registers.
    typedef struct packed {
        logic  fire;
        mode_t mode;
    } color_step_t;

endpackage

`default_nettype wire

>>> rtl/core/bcmc_color.sv
// Hue, saturation and value registers with their step logic.
`default_nettype none

module bcmc_color (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  bcmc_pkg::color_step_t step,
    output logic [8:0]           hue,
    output logic [7:0]           sat,
    output logic [7:0]           val
);
    import bcmc_pkg::*;

    logic [8:0] hue_reg, hue_next, hue_sum;
    logic [7:0] sat_reg, sat_next;
    logic [7:0] val_reg, val_next;

    assign hue_sum = hue_reg + HUE_STEP;

    always_comb begin
        hue_next = hue_reg;
        sat_next = sat_reg;
        val_next = val_reg;
        if (step.fire) begin
            case (step.mode)
                MODE_SLOW: begin
                    hue_next = (hue_sum >= HUE_WRAP) ? hue_sum - HUE_WRAP : hue_sum;
                end
                MODE_FAST: begin
                    sat_next = (sat_reg < SV_LIMIT) ? sat_reg + SV_STEP : '0;
                end
                MODE_STEADY: begin
                    val_next = (val_reg < SV_LIMIT) ? val_reg + SV_STEP : '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hue_reg <= HUE_RESET;
            sat_reg <= SV_RESET;
            val_reg <= SV_RESET;
        end else begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            val_reg <= val_next;
        end
    end

    assign hue = hue_reg;
    assign sat = sat_reg;
    assign val = val_reg;

endmodule

`default_nettype wire

>>> rtl/core/button_click_mode_controller.sv
// A result is valid once the state registers have loaded its accepted input.
// Throughput: one transaction per cycle unless m_ready stalls; the input register
// and the state registers (which double as the result register) are one stage
// each. Reset (aresetn low, synchronous) restores the configuration defaults, idles
// all timers, clears the mode and LED, and sets the color to 356/255/255.
`default_nettype none

module button_click_mode_controller #(
    parameter int TIMER_BITS = 16
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                cfg_wr_en,
    input  wire  [bcmc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire  [bcmc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire                                s_valid,
    output logic                               s_ready,
    input  wire                                s_button_level,
    input  wire                                s_adjust_strobe,
    output logic                               m_valid,
    input  wire                                m_ready,
    output logic                               m_led_out,
    output logic [1:0]                         m_mode_now,
    output logic [8:0]                         m_hue_now,
    output logic [7:0]                         m_sat_now,
    output logic [7:0]                         m_val_now,
    output logic                               m_long_held,
    output logic                               m_color_changed
);
    import bcmc_pkg::*;

    // Configuration registers.
    logic [7:0]  deb_cfg_reg;
    logic [15:0] long_cfg_reg, dbl_cfg_reg, slow_cfg_reg, fast_cfg_reg;

    // Input register.
    logic in_valid_reg, in_level_reg, in_strobe_reg;
    logic advance;

    // Control state.
    logic                  last_level_reg, last_level_next;
    logic [7:0]            deb_left_reg, deb_left_next;
    logic [TIMER_BITS-1:0] long_left_reg, long_left_next;
    logic [TIMER_BITS-1:0] dbl_left_reg, dbl_left_next;
    logic [TIMER_BITS-1:0] blink_left_reg, blink_left_next;
    press_t                press_reg, press_next;
    logic                  await_first_reg, await_first_next;
    mode_t                 mode_reg, mode_next;
    logic                  phase_reg, phase_next;
    logic                  led_reg, led_next;
    logic                  changed_reg;
    logic                  m_valid_reg;

    logic deb_fire, long_fire, dbl_fire, blink_fire;
    color_step_t color_step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deb_cfg_reg  <= DEBOUNCE_RESET;
            long_cfg_reg <= LONG_PRESS_RESET;
            dbl_cfg_reg  <= DBL_CLICK_RESET;
            slow_cfg_reg <= SLOW_BLINK_RESET;
            fast_cfg_reg <= FAST_BLINK_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_DEBOUNCE:   deb_cfg_reg  <= cfg_wdata[7:0];
                REG_LONG_PRESS: long_cfg_reg <= cfg_wdata;
                REG_DBL_CLICK:  dbl_cfg_reg  <= cfg_wdata;
                REG_SLOW_BLINK: slow_cfg_reg <= cfg_wdata;
                REG_FAST_BLINK: fast_cfg_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // The tick in the input register is processed once the result slot is free.
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_level_reg  <= s_button_level;
            in_strobe_reg <= s_adjust_strobe;
        end
    end

    always_comb begin
        // Count down every running timer; reaching zero is an expiry.
        deb_left_next   = (deb_left_reg != '0) ? deb_left_reg - 1'b1 : deb_left_reg;
        long_left_next  = (long_left_reg != '0) ? long_left_reg - 1'b1 : long_left_reg;
        dbl_left_next   = (dbl_left_reg != '0) ? dbl_left_reg - 1'b1 : dbl_left_reg;
        blink_left_next = (blink_left_reg != '0) ? blink_left_reg - 1'b1 : blink_left_reg;
        deb_fire   = (deb_left_reg == 8'd1);
        long_fire  = (long_left_reg == TIMER_BITS'(1));
        dbl_fire   = (dbl_left_reg == TIMER_BITS'(1));
        blink_fire = (blink_left_reg == TIMER_BITS'(1));

        last_level_next  = last_level_reg;
        press_next       = press_reg;
        await_first_next = await_first_reg;
        mode_next        = mode_reg;
        phase_next       = phase_reg;
        led_next         = led_reg;

        if (in_level_reg != last_level_reg) begin
            last_level_next = in_level_reg;
            deb_left_next   = deb_cfg_reg;
            deb_fire        = 1'b0;
        end

        if (deb_fire) begin
            if (!in_level_reg) begin
                press_next     = PRESS_ON;
                led_next       = 1'b1;
                long_left_next = TIMER_BITS'(long_cfg_reg);
                long_fire      = 1'b0;
            end else begin
                long_left_next = '0;
                long_fire      = 1'b0;
                if (press_reg == PRESS_ON) begin
                    if (await_first_reg) begin
                        await_first_next = 1'b0;
                        dbl_left_next    = TIMER_BITS'(dbl_cfg_reg);
                        dbl_fire         = 1'b0;
                    end else begin
                        // Second click: step the mode and restart the LED pattern.
                        await_first_next = 1'b1;
                        mode_next        = mode_reg + 2'd1;
                        blink_left_next  = '0;
                        blink_fire       = 1'b0;
                        led_next         = (mode_next != MODE_OFF);
                        if (mode_next == MODE_SLOW) begin
                            blink_left_next = TIMER_BITS'(slow_cfg_reg);
                        end else if (mode_next == MODE_FAST) begin
                            blink_left_next = TIMER_BITS'(fast_cfg_reg);
                        end
                    end
                end
                press_next = PRESS_OFF;
            end
        end

        if (long_fire && !in_level_reg) begin
            press_next = PRESS_LONG;
        end

        if (dbl_fire && !await_first_next) begin
            await_first_next = 1'b1;
        end

        if (blink_fire) begin
            phase_next = ~phase_reg;
            led_next   = ~phase_reg;
            if (mode_next == MODE_SLOW) begin
                blink_left_next = TIMER_BITS'(slow_cfg_reg);
            end else if (mode_next == MODE_FAST) begin
                blink_left_next = TIMER_BITS'(fast_cfg_reg);
            end
        end

        color_step.fire = advance && in_strobe_reg && (press_next == PRESS_LONG)
                          && (mode_next != MODE_OFF);
        color_step.mode = mode_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_level_reg  <= 1'b1;
            deb_left_reg    <= '0;
            long_left_reg   <= '0;
            dbl_left_reg    <= '0;
            blink_left_reg  <= '0;
            press_reg       <= PRESS_OFF;
            await_first_reg <= 1'b1;
            mode_reg        <= MODE_OFF;
            phase_reg       <= 1'b0;
            led_reg         <= 1'b0;
            changed_reg     <= 1'b0;
        end else if (advance) begin
            last_level_reg  <= last_level_next;
            deb_left_reg    <= deb_left_next;
            long_left_reg   <= long_left_next;
            dbl_left_reg    <= dbl_left_next;
            blink_left_reg  <= blink_left_next;
            press_reg       <= press_next;
            await_first_reg <= await_first_next;
            mode_reg        <= mode_next;
            phase_reg       <= phase_next;
            led_reg         <= led_next;
            changed_reg     <= color_step.fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    bcmc_color u_color (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (color_step),
        .hue     (m_hue_now),
        .sat     (m_sat_now),
        .val     (m_val_now)
    );

    // State only moves when a result is loaded, so it serves as the result register.
    assign m_valid         = m_valid_reg;
    assign m_led_out       = led_reg;
    assign m_mode_now      = mode_reg;
    assign m_long_held     = (press_reg == PRESS_LONG);
    assign m_color_changed = changed_reg;

endmodule

`default_nettype wire

>>> rtl/core/bcmc_checker.sv
// Port-level checker for the button click mode controller, with its bind.
`default_nettype none

module bcmc_checker (
    input wire                             aclk,
    input wire                             aresetn,
    input wire                             m_valid,
    input wire                             m_ready,
    input wire                             m_led_out,
    input wire [1:0]                       m_mode_now,
    input wire [8:0]                       m_hue_now,
    input wire [7:0]                       m_sat_now,
    input wire [7:0]                       m_val_now,
    input wire                             m_long_held,
    input wire                             m_color_changed
);
    import bcmc_pkg::*;

    // A stalled result transaction keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_mode_now) && $stable(m_led_out)
        && $stable(m_hue_now) && $stable(m_sat_now) && $stable(m_val_now)))
        else $error("result changed while stalled");

    // The mode only ever advances by one.
    a_mode_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_mode_now != $past(m_mode_now)) |-> (m_mode_now == 2'($past(m_mode_now) + 2'd1)))
        else $error("mode skipped a step");

    // A color step needs a long press and an active mode.
    a_color_cond: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_color_changed) |-> (m_long_held && (m_mode_now != MODE_OFF)))
        else $error("color stepped without long press");

    // The value mode holds the LED on steadily.
    a_val_led: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_mode_now == MODE_STEADY) |-> m_led_out)
        else $error("LED dark in value mode");

    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_hue_now < HUE_WRAP)
        else $error("hue out of range");

endmodule

bind button_click_mode_controller bcmc_checker u_bcmc_checker (.*);

`default_nettype wire
